>>> rtl/ctgp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctgp_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam logic [8:0] RST_TILE_WIDTH  = 9'd32;
    localparam logic [8:0] RST_TILE_HEIGHT = 9'd32;
    localparam logic [6:0] RST_MAP_COLS    = 7'd64;
    localparam logic [6:0] RST_MAP_ROWS    = 7'd64;

    typedef enum logic [1:0] {
        CFG_TILE_WIDTH  = 2'd0,
        CFG_TILE_HEIGHT = 2'd1,
        CFG_MAP_COLS    = 2'd2,
        CFG_MAP_ROWS    = 2'd3
    } cfg_index_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SIDE   = 2'd1;
    localparam logic [1:0] KIND_CORNER = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVX,
        ST_DIVY,
        ST_NB_RD,
        ST_NB_USE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SQ_LOAD,
        ST_SQRT,
        ST_CMP,
        ST_SC_MUL,
        ST_SC_LOAD,
        ST_SC_DIV,
        ST_DONE
    } state_t;

    function automatic logic [23:0] sat24(input logic signed [25:0] v);
        logic [23:0] r;
        if (v > 26'sd8388607)
            r = 24'h7FFFFF;
        else if (v < -26'sd8388608)
            r = 24'h800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/circle_tile_grid_pushout_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   s_tuser command, s_tdata tile write and query fields
// m_*       out        m_tvalid / m_tready   m_tuser collided and contact kind, m_tdata adjustments
// cfg_*     in         cfg_we                cfg_addr register index, cfg_wdata value
//
// A tile write is taken in IDLE. A query runs the two tile divisions and the four side reads,
// then the squares and square root for each blocked corner, and the two scaled divisions on a
// corner hit, before it ends in DONE.
// All of it runs through one shared shift-subtract unit and one 17x17 multiplier.
// After reset all MAX_COLS * MAX_ROWS cells of the tile memory are cleared with s_tready low.
// A finished result waits in the output register while the next request is taken.

module circle_tile_grid_pushout_core #(
    parameter int MAX_COLS = ctgp_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = ctgp_pkg::DEF_MAX_ROWS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // tile_col, tile_row, tile_value, center_x, center_y,
                                         // radius, prior_adjust_x, prior_adjust_y, zero fill
    input  wire logic         s_tuser,   // command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,   // adjust_x, adjust_y
    output logic [2:0]        m_tuser,   // collided, contact_kind
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [8:0]   cfg_wdata
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);

    ctgp_pkg::state_t state_reg, state_next;

    logic [8:0]  tile_width_reg, tile_height_reg;
    logic [6:0]  map_cols_reg, map_rows_reg;

    logic        mem [DEPTH];
    logic        rd_bit_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, rd_addr, clr_addr_reg;
    logic        mem_wdata;

    logic [21:0] cx_reg, cy_reg;
    logic [15:0] r_reg;
    logic [13:0] tx_reg, ty_reg;
    logic [16:0] ox_reg, oy_reg;
    logic signed [25:0] acc_x_reg, acc_y_reg;
    logic [1:0]  kind_reg;
    logic [2:0]  k_reg;
    logic        inr_reg;
    logic        axis_reg;
    logic [16:0] len_reg;
    logic [16:0] mag_x_reg;

    logic [33:0] src_reg;
    logic [19:0] rem_reg;
    logic [16:0] q_reg;
    logic [16:0] div_d_reg;
    logic [5:0]  cnt_reg;
    logic [33:0] prod_reg, sum_reg;

    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic [2:0]  out_user_reg;

    logic        s_acc, out_free, last_step, blk;
    logic [8:0]  w_eff, h_eff;
    logic [16:0] tw17, th17, rx, ry;
    logic [10:0] cols_lim, rows_lim;
    logic signed [15:0] dcol, drow, col_s, row_s;
    logic        nb_inr;

    logic        sqrt_mode, ge;
    logic [19:0] rem_sh, trial, rem_next;
    logic [16:0] q_next;
    logic [33:0] src_next;
    logic [34:0] sq_sum;

    logic [16:0] mul_a, mul_b, dx, dy, off_sel;
    logic [33:0] prod;

    logic        side_hit, left_c, right_c, top_c, bot_c;
    logic [17:0] right_t, bot_t;
    logic [1:0]  kind_after;
    logic        wr_in_range;
    logic [AW-1:0] wr_addr;
    logic signed [25:0] fin_x, fin_y;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign last_step = (cnt_reg == 6'd1);
    assign blk = inr_reg && rd_bit_reg;

    assign w_eff = (tile_width_reg == 9'd0) ? 9'd1 : tile_width_reg;
    assign h_eff = (tile_height_reg == 9'd0) ? 9'd1 : tile_height_reg;
    assign tw17  = {w_eff, 8'd0};
    assign th17  = {h_eff, 8'd0};
    assign rx    = tw17 - ox_reg;
    assign ry    = th17 - oy_reg;

    assign cols_lim = (11'(map_cols_reg) > 11'(MAX_COLS)) ? 11'(MAX_COLS) : 11'(map_cols_reg);
    assign rows_lim = (11'(map_rows_reg) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(map_rows_reg);

    always_comb
    begin
        dcol = 16'sd0;
        drow = 16'sd0;
        if (k_reg inside {3'd0, 3'd4, 3'd7})
            dcol = -16'sd1;
        else if (k_reg inside {3'd1, 3'd5, 3'd6})
            dcol = 16'sd1;
        if (k_reg inside {3'd2, 3'd4, 3'd5})
            drow = -16'sd1;
        else if (k_reg inside {3'd3, 3'd6, 3'd7})
            drow = 16'sd1;
    end

    assign col_s  = $signed({2'b00, tx_reg}) + dcol;
    assign row_s  = $signed({2'b00, ty_reg}) + drow;
    assign nb_inr = !col_s[15] && !row_s[15] && (col_s < $signed({5'd0, cols_lim}))
                    && (row_s < $signed({5'd0, rows_lim}));
    assign rd_addr = nb_inr ? (AW'(row_s[RW-1:0]) * AW'(MAX_COLS) + AW'(col_s[CW-1:0]))
                            : '0;

    assign wr_in_range = ({5'd0, s_tdata[5:0]} < 11'(MAX_COLS))
                         && ({5'd0, s_tdata[11:6]} < 11'(MAX_ROWS));
    assign wr_addr = AW'(s_tdata[11:6]) * AW'(MAX_COLS) + AW'(s_tdata[5:0]);

    // Shared shift-subtract unit: restoring division or bit-pair square root.
    assign sqrt_mode = (state_reg == ctgp_pkg::ST_SQRT);
    always_comb
    begin
        if (sqrt_mode)
        begin
            rem_sh   = {rem_reg[17:0], src_reg[33:32]};
            trial    = {1'b0, q_reg, 2'b01};
            src_next = {src_reg[31:0], 2'b00};
        end
        else
        begin
            rem_sh   = {rem_reg[18:0], src_reg[33]};
            trial    = {3'd0, div_d_reg};
            src_next = {src_reg[32:0], 1'b0};
        end
        ge       = (rem_sh >= trial);
        rem_next = ge ? (rem_sh - trial) : rem_sh;
        q_next   = {q_reg[15:0], ge};
    end

    // A sum of squares beyond 34 bits is farther than any radius, so it is clipped.
    assign sq_sum = 35'(sum_reg) + 35'(prod_reg);

    assign dx = (k_reg inside {3'd4, 3'd7}) ? ox_reg : rx;
    assign dy = (k_reg inside {3'd4, 3'd5}) ? oy_reg : ry;
    assign off_sel = axis_reg ? dy : dx;

    always_comb
    begin
        case (state_reg)
            ctgp_pkg::ST_MUL_A:
            begin
                mul_a = dx;
                mul_b = dx;
            end
            ctgp_pkg::ST_MUL_B:
            begin
                mul_a = dy;
                mul_b = dy;
            end
            default:
            begin
                mul_a = off_sel;
                mul_b = {1'b0, r_reg - len_reg[15:0]};
            end
        endcase
    end
    assign prod = 34'(mul_a) * 34'(mul_b);

    assign right_t = 18'(ox_reg) + 18'(r_reg);
    assign bot_t   = 18'(oy_reg) + 18'(r_reg);
    assign left_c  = (ox_reg < 17'(r_reg));
    assign right_c = (right_t > 18'(tw17));
    assign top_c   = (oy_reg < 17'(r_reg));
    assign bot_c   = (bot_t > 18'(th17));

    always_comb
    begin
        case (k_reg)
            3'd0:    side_hit = blk && left_c;
            3'd1:    side_hit = blk && right_c;
            3'd2:    side_hit = blk && top_c;
            3'd3:    side_hit = blk && bot_c;
            default: side_hit = 1'b0;
        endcase
        kind_after = side_hit ? ctgp_pkg::KIND_SIDE : kind_reg;
    end

    assign fin_x = (k_reg inside {3'd4, 3'd7}) ? $signed({9'd0, mag_x_reg})
                                               : -$signed({9'd0, mag_x_reg});
    assign fin_y = (k_reg inside {3'd4, 3'd5}) ? $signed({9'd0, q_next})
                                               : -$signed({9'd0, q_next});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctgp_pkg::ST_CLEAR:
                if (clr_addr_reg == AW'(DEPTH - 1))
                    state_next = ctgp_pkg::ST_IDLE;
            ctgp_pkg::ST_IDLE:
                if (s_acc && s_tuser == ctgp_pkg::CMD_QUERY)
                    state_next = ctgp_pkg::ST_DIVX;
            ctgp_pkg::ST_DIVX:
                if (last_step)
                    state_next = ctgp_pkg::ST_DIVY;
            ctgp_pkg::ST_DIVY:
                if (last_step)
                    state_next = ctgp_pkg::ST_NB_RD;
            ctgp_pkg::ST_NB_RD:
                state_next = ctgp_pkg::ST_NB_USE;
            ctgp_pkg::ST_NB_USE:
                if (!k_reg[2])
                begin
                    if (k_reg == 3'd3 && kind_after != ctgp_pkg::KIND_NONE)
                        state_next = ctgp_pkg::ST_DONE;
                    else
                        state_next = ctgp_pkg::ST_NB_RD;
                end
                else if (blk)
                    state_next = ctgp_pkg::ST_MUL_A;
                else if (k_reg == 3'd7)
                    state_next = ctgp_pkg::ST_DONE;
                else
                    state_next = ctgp_pkg::ST_NB_RD;
            ctgp_pkg::ST_MUL_A:
                state_next = ctgp_pkg::ST_MUL_B;
            ctgp_pkg::ST_MUL_B:
                state_next = ctgp_pkg::ST_SQ_LOAD;
            ctgp_pkg::ST_SQ_LOAD:
                state_next = ctgp_pkg::ST_SQRT;
            ctgp_pkg::ST_SQRT:
                if (last_step)
                    state_next = ctgp_pkg::ST_CMP;
            ctgp_pkg::ST_CMP:
                if (q_reg < {1'b0, r_reg})
                    state_next = ctgp_pkg::ST_SC_MUL;
                else if (k_reg == 3'd7)
                    state_next = ctgp_pkg::ST_DONE;
                else
                    state_next = ctgp_pkg::ST_NB_RD;
            ctgp_pkg::ST_SC_MUL:
                state_next = ctgp_pkg::ST_SC_LOAD;
            ctgp_pkg::ST_SC_LOAD:
                state_next = ctgp_pkg::ST_SC_DIV;
            ctgp_pkg::ST_SC_DIV:
                if (last_step)
                    state_next = axis_reg ? ctgp_pkg::ST_DONE : ctgp_pkg::ST_SC_MUL;
            ctgp_pkg::ST_DONE:
                if (out_free)
                    state_next = ctgp_pkg::ST_IDLE;
            default:
                state_next = ctgp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = 1'b0;
        case (state_reg)
            ctgp_pkg::ST_CLEAR:
                mem_we = 1'b1;
            ctgp_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                mem_we    = s_tvalid && s_tuser == ctgp_pkg::CMD_WRITE && wr_in_range;
                mem_waddr = wr_addr;
                mem_wdata = s_tdata[12];
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_bit_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ctgp_pkg::ST_CLEAR;
            clr_addr_reg    <= '0;
            tile_width_reg  <= ctgp_pkg::RST_TILE_WIDTH;
            tile_height_reg <= ctgp_pkg::RST_TILE_HEIGHT;
            map_cols_reg    <= ctgp_pkg::RST_MAP_COLS;
            map_rows_reg    <= ctgp_pkg::RST_MAP_ROWS;
            out_valid_reg   <= 1'b0;
            k_reg           <= '0;
            axis_reg        <= 1'b0;
            kind_reg        <= ctgp_pkg::KIND_NONE;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_addr)
                    ctgp_pkg::CFG_TILE_WIDTH:  tile_width_reg  <= cfg_wdata;
                    ctgp_pkg::CFG_TILE_HEIGHT: tile_height_reg <= cfg_wdata;
                    ctgp_pkg::CFG_MAP_COLS:    map_cols_reg    <= cfg_wdata[6:0];
                    ctgp_pkg::CFG_MAP_ROWS:    map_rows_reg    <= cfg_wdata[6:0];
                    default:                   map_rows_reg    <= map_rows_reg;
                endcase
            end

            if (m_tready && !(state_reg == ctgp_pkg::ST_DONE && out_free))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ctgp_pkg::ST_CLEAR:
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                ctgp_pkg::ST_IDLE:
                    if (s_acc && s_tuser == ctgp_pkg::CMD_QUERY)
                    begin
                        cx_reg    <= s_tdata[34:13];
                        cy_reg    <= s_tdata[56:35];
                        r_reg     <= s_tdata[72:57];
                        acc_x_reg <= 26'($signed(s_tdata[96:73]));
                        acc_y_reg <= 26'($signed(s_tdata[120:97]));
                        src_reg   <= {s_tdata[34:21], 20'd0};
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        div_d_reg <= {8'd0, w_eff};
                        cnt_reg   <= 6'd14;
                        kind_reg  <= ctgp_pkg::KIND_NONE;
                    end
                ctgp_pkg::ST_DIVX, ctgp_pkg::ST_DIVY, ctgp_pkg::ST_SQRT, ctgp_pkg::ST_SC_DIV:
                begin
                    if (last_step && state_reg == ctgp_pkg::ST_DIVX)
                    begin
                        tx_reg    <= q_next[13:0];
                        ox_reg    <= {rem_next[8:0], cx_reg[7:0]};
                        src_reg   <= {cy_reg[21:8], 20'd0};
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        div_d_reg <= {8'd0, h_eff};
                        cnt_reg   <= 6'd14;
                    end
                    else
                    begin
                        src_reg <= src_next;
                        rem_reg <= rem_next;
                        q_reg   <= q_next;
                        cnt_reg <= cnt_reg - 6'd1;
                        if (last_step)
                        begin
                            if (state_reg == ctgp_pkg::ST_DIVY)
                            begin
                                ty_reg <= q_next[13:0];
                                oy_reg <= {rem_next[8:0], cy_reg[7:0]};
                                k_reg  <= 3'd0;
                            end
                            else if (state_reg == ctgp_pkg::ST_SC_DIV)
                            begin
                                if (!axis_reg)
                                begin
                                    mag_x_reg <= q_next;
                                    axis_reg  <= 1'b1;
                                end
                                else
                                begin
                                    acc_x_reg <= fin_x;
                                    acc_y_reg <= fin_y;
                                    kind_reg  <= ctgp_pkg::KIND_CORNER;
                                end
                            end
                        end
                    end
                end
                ctgp_pkg::ST_NB_RD:
                    inr_reg <= nb_inr;
                ctgp_pkg::ST_NB_USE:
                begin
                    kind_reg <= kind_after;
                    if (side_hit)
                    begin
                        case (k_reg)
                            3'd0: acc_x_reg <= acc_x_reg + $signed({9'd0, 17'(r_reg) - ox_reg});
                            3'd1: acc_x_reg <= acc_x_reg - $signed({8'd0, right_t - 18'(tw17)});
                            3'd2: acc_y_reg <= acc_y_reg + $signed({9'd0, 17'(r_reg) - oy_reg});
                            default: acc_y_reg <= acc_y_reg - $signed({8'd0, bot_t - 18'(th17)});
                        endcase
                    end
                    if (!(k_reg[2] && blk))
                        k_reg <= k_reg + 3'd1;
                end
                ctgp_pkg::ST_MUL_A:
                    prod_reg <= prod;
                ctgp_pkg::ST_MUL_B:
                begin
                    sum_reg  <= prod_reg;
                    prod_reg <= prod;
                end
                ctgp_pkg::ST_SQ_LOAD:
                begin
                    src_reg <= sq_sum[34] ? '1 : sq_sum[33:0];
                    rem_reg <= '0;
                    q_reg   <= '0;
                    cnt_reg <= 6'd17;
                end
                ctgp_pkg::ST_CMP:
                begin
                    len_reg  <= q_reg;
                    axis_reg <= 1'b0;
                    if (q_reg >= {1'b0, r_reg})
                        k_reg <= k_reg + 3'd1;
                end
                ctgp_pkg::ST_SC_MUL:
                    prod_reg <= prod;
                ctgp_pkg::ST_SC_LOAD:
                begin
                    src_reg   <= prod_reg;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    div_d_reg <= {1'b0, r_reg};
                    cnt_reg   <= 6'd34;
                end
                ctgp_pkg::ST_DONE:
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {ctgp_pkg::sat24(acc_y_reg),
                                          ctgp_pkg::sat24(acc_x_reg)};
                        out_user_reg  <= {kind_reg, kind_reg != ctgp_pkg::KIND_NONE};
                    end
                default:
                    cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

>>> tb/circle_tile_grid_pushout_core_tb.sv
`timescale 1ns / 1ps

module circle_tile_grid_pushout_core_tb;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 250;

    typedef struct {
        logic              cmd;
        logic [5:0]        col;
        logic [5:0]        row;
        logic              val;
        logic [21:0]       cx;
        logic [21:0]       cy;
        logic [15:0]       rad;
        logic signed [23:0] pax;
        logic signed [23:0] pay;
    } request_t;

    typedef struct {
        logic        collided;
        logic [1:0]  kind;
        logic [23:0] ax;
        logic [23:0] ay;
    } pushout_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [127:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [47:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_we;
    logic [1:0] cfg_addr;
    logic [8:0] cfg_wdata;

    request_t pending_q[$];
    pushout_t pushout_q[$];
    request_t held;

    bit [4095:0] tile_map;
    logic [8:0] tile_w;
    logic [8:0] tile_h;
    logic [6:0] cols_used;
    logic [6:0] rows_used;

    int errors;
    int burst_left;
    int gap_left;
    int stall_cycles;
    int rx_count;
    int queries;
    int kind_seen[3];

    circle_tile_grid_pushout_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit tile_is_solid(longint c, longint r);
        longint nc;
        longint nr;
        nc = cols_used > 64 ? 64 : cols_used;
        nr = rows_used > 64 ? 64 : rows_used;
        if (c < 0 || r < 0 || c >= nc || r >= nr)
            return 1'b0;
        return tile_map[r * 64 + c];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [23:0] clamp24(longint v);
        if (v > 8388607)
            return 24'h7FFFFF;
        if (v < -8388608)
            return 24'h800000;
        return v[23:0];
    endfunction

    function automatic pushout_t predict_pushout(request_t q);
        pushout_t res;
        longint tw, th, tx, ty, ox, oy, r, ax, ay, hx, hy, len, sx, sy;
        int kind;
        tw = (tile_w == 0 ? 1 : tile_w) * 256;
        th = (tile_h == 0 ? 1 : tile_h) * 256;
        tx = q.cx / tw;
        ty = q.cy / th;
        ox = q.cx - tx * tw;
        oy = q.cy - ty * th;
        r = q.rad;
        ax = q.pax;
        ay = q.pay;
        kind = 0;
        if (ox < r && tile_is_solid(tx - 1, ty))
        begin
            ax += r - ox;
            kind = 1;
        end
        if (ox + r > tw && tile_is_solid(tx + 1, ty))
        begin
            ax -= ox + r - tw;
            kind = 1;
        end
        if (oy < r && tile_is_solid(tx, ty - 1))
        begin
            ay += r - oy;
            kind = 1;
        end
        if (oy + r > th && tile_is_solid(tx, ty + 1))
        begin
            ay -= oy + r - th;
            kind = 1;
        end
        // Corners in order top-left, top-right, bottom-right, bottom-left.
        for (int k = 0; k < 4 && kind == 0; k++)
        begin
            sx = (k == 0 || k == 3) ? 1 : -1;
            sy = (k < 2) ? 1 : -1;
            hx = sx > 0 ? ox : tw - ox;
            hy = sy > 0 ? oy : th - oy;
            len = int_sqrt(hx * hx + hy * hy);
            if (len < r && tile_is_solid(tx - sx, ty - sy))
            begin
                ax = sx * ((hx * (r - len)) / r);
                ay = sy * ((hy * (r - len)) / r);
                kind = 2;
            end
        end
        res.collided = kind != 0;
        res.kind = kind == 2 ? ctgp_pkg::KIND_CORNER
                             : (kind == 1 ? ctgp_pkg::KIND_SIDE : ctgp_pkg::KIND_NONE);
        res.ax = clamp24(ax);
        res.ay = clamp24(ay);
        return res;
    endfunction

    function automatic request_t tile_write(int c, int r, bit v);
        request_t q;
        q = '{default: '0};
        q.cmd = ctgp_pkg::CMD_WRITE;
        q.col = 6'(c);
        q.row = 6'(r);
        q.val = v;
        return q;
    endfunction

    function automatic request_t circle_query(longint x, longint y, int r, int px, int py);
        request_t q;
        q = '{default: '0};
        q.cmd = ctgp_pkg::CMD_QUERY;
        q.cx = 22'(x);
        q.cy = 22'(y);
        q.rad = 16'(r);
        q.pax = 24'(px);
        q.pay = 24'(py);
        return q;
    endfunction

    task automatic add_request(request_t q);
        pending_q.insert(pending_q.size(), q);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (held.cmd == ctgp_pkg::CMD_WRITE)
                    tile_map[held.row * 64 + held.col] = held.val;
                else
                begin
                    pushout_q.insert(pushout_q.size(), predict_pushout(held));
                    queries++;
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    held = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= held.cmd;
                    s_tdata <= {7'd0, held.pay, held.pax, held.rad, held.cy, held.cx,
                                held.val, held.row, held.col};
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        pushout_t got;
        pushout_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_count <= 0;
        end
        else
        begin
            rx_count <= rx_count + 1;
            if ((rx_count / 300) % 3 == 0)
                m_tready <= 1'b1;
            else if ((rx_count / 300) % 3 == 1)
                m_tready <= $urandom_range(0, 3) != 0;
            else
                m_tready <= $urandom_range(0, 4) == 0;
            if (m_tvalid && m_tready)
            begin
                got.collided = m_tuser[0];
                got.kind = m_tuser[2:1];
                got.ax = m_tdata[23:0];
                got.ay = m_tdata[47:24];
                if (pushout_q.size() == 0)
                begin
                    $display("%0t: unexpected result collided=%0b kind=%0d ax=%h ay=%h",
                             $time, got.collided, got.kind, got.ax, got.ay);
                    errors++;
                end
                else
                begin
                    want = pushout_q.pop_front();
                    if (got.kind <= 2)
                        kind_seen[got.kind]++;
                    if (got.collided !== want.collided)
                    begin
                        $display("%0t: collided expected %0b actual %0b",
                                 $time, want.collided, got.collided);
                        errors++;
                    end
                    if (got.kind !== want.kind)
                    begin
                        $display("%0t: contact_kind expected %0d actual %0d",
                                 $time, want.kind, got.kind);
                        errors++;
                    end
                    if (got.ax !== want.ax)
                    begin
                        $display("%0t: adjust_x expected %h actual %h", $time, want.ax, got.ax);
                        errors++;
                    end
                    if (got.ay !== want.ay)
                    begin
                        $display("%0t: adjust_y expected %h actual %h", $time, want.ay, got.ay);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(ctgp_pkg::cfg_index_t idx, logic [8:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ctgp_pkg::CFG_TILE_WIDTH:  tile_w = value;
            ctgp_pkg::CFG_TILE_HEIGHT: tile_h = value;
            ctgp_pkg::CFG_MAP_COLS:    cols_used = value[6:0];
            default:                   rows_used = value[6:0];
        endcase
    endtask

    task automatic drain;
        wait (pending_q.size() == 0 && !s_tvalid && pushout_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        longint tw;
        longint th;
        int pick;
        int rmax;
        tw = (tile_w == 0 ? 1 : tile_w) * 256;
        th = (tile_h == 0 ? 1 : tile_h) * 256;
        rmax = tw > 65535 ? 65535 : tw;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                if ($urandom_range(0, 4) == 0)
                    add_request(tile_write($urandom_range(0, 63),
                                           $urandom_range(0, 63), $urandom_range(0, 1)));
                else
                    add_request(tile_write($urandom_range(0, 9),
                                           $urandom_range(0, 9), $urandom_range(0, 1)));
            end
            else if (pick < 90)
                add_request(circle_query(
                    ($urandom_range(0, 9) * tw + $urandom % tw) & 22'h3FFFFF,
                    ($urandom_range(0, 9) * th + $urandom % th) & 22'h3FFFFF,
                    $urandom_range(0, rmax),
                    $signed($urandom_range(0, 4095)) - 2048,
                    $signed($urandom_range(0, 4095)) - 2048));
            else
                add_request(circle_query($urandom, $urandom, $urandom,
                                         $urandom, $urandom));
        end
    endtask

    initial
    begin
        errors = 0;
        queries = 0;
        kind_seen = '{0, 0, 0};
        tile_map = '0;
        tile_w = ctgp_pkg::RST_TILE_WIDTH;
        tile_h = ctgp_pkg::RST_TILE_HEIGHT;
        cols_used = ctgp_pkg::RST_MAP_COLS;
        rows_used = ctgp_pkg::RST_MAP_ROWS;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (s_tready);

        // Each neighbor of tile (2,2) in turn: block it, probe it, free it again.
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                if (dx != 0 || dy != 0)
                begin
                    add_request(tile_write(2 + dx, 2 + dy, 1));
                    add_request(circle_query(
                        16384 + (dx < 0 ? 100 : (dx > 0 ? 8092 : 4096)),
                        16384 + (dy < 0 ? 100 : (dy > 0 ? 8092 : 4096)),
                        512, dx < 0 ? 8388607 : -8388608, dy < 0 ? 8388607 : -8388608));
                    add_request(tile_write(2 + dx, 2 + dy, 0));
                end
        add_request(tile_write(1, 2, 1));
        add_request(circle_query(16384, 16384 + 4096, 0, 0, 0));
        add_request(circle_query(22'h3FFFFF, 22'h3FFFFF, 16'hFFFF, -1, -1));
        drain();

        random_phase(145);
        drain();
        write_reg(ctgp_pkg::CFG_TILE_WIDTH, 9'd1);
        write_reg(ctgp_pkg::CFG_TILE_HEIGHT, 9'd1);
        write_reg(ctgp_pkg::CFG_MAP_COLS, 9'd4);
        write_reg(ctgp_pkg::CFG_MAP_ROWS, 9'd4);
        random_phase(145);
        drain();
        write_reg(ctgp_pkg::CFG_TILE_WIDTH, 9'd0);
        write_reg(ctgp_pkg::CFG_TILE_HEIGHT, 9'd0);
        write_reg(ctgp_pkg::CFG_MAP_COLS, 9'd0);
        write_reg(ctgp_pkg::CFG_MAP_ROWS, 9'd0);
        random_phase(80);
        drain();
        write_reg(ctgp_pkg::CFG_MAP_COLS, 9'd127);
        write_reg(ctgp_pkg::CFG_MAP_ROWS, 9'd127);
        random_phase(130);
        drain();
        write_reg(ctgp_pkg::CFG_TILE_WIDTH, 9'd256);
        write_reg(ctgp_pkg::CFG_TILE_HEIGHT, 9'd256);
        write_reg(ctgp_pkg::CFG_MAP_COLS, 9'd64);
        write_reg(ctgp_pkg::CFG_MAP_ROWS, 9'd64);
        random_phase(145);
        drain();
        write_reg(ctgp_pkg::CFG_TILE_WIDTH, 9'd511);
        write_reg(ctgp_pkg::CFG_TILE_HEIGHT, 9'd3);
        write_reg(ctgp_pkg::CFG_MAP_COLS, 9'd6);
        write_reg(ctgp_pkg::CFG_MAP_ROWS, 9'd65);
        random_phase(130);
        drain();
        write_reg(ctgp_pkg::CFG_TILE_WIDTH, 9'($urandom_range(2, 64)));
        write_reg(ctgp_pkg::CFG_TILE_HEIGHT, 9'($urandom_range(2, 64)));
        write_reg(ctgp_pkg::CFG_MAP_COLS, 9'($urandom_range(1, 10)));
        write_reg(ctgp_pkg::CFG_MAP_ROWS, 9'($urandom_range(1, 10)));
        random_phase(145);
        drain();

        $display("Ran %0d circle queries across seven tile and map settings.", queries);
        $display("Results: %0d clear, %0d side pushes, %0d corner pushes.",
                 kind_seen[0], kind_seen[1], kind_seen[2]);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
